@@ rtl/mad_pkg.sv @@
// ---------------------------------------------------------------------------
// mad_pkg
// types, constants and helpers shared by the motion adaptive deinterlacer
// ---------------------------------------------------------------------------
package mad_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [PIX_W-1:0] pix_t;

	// spike margins and the upper clamp of the high bound
	localparam pix_t MARGIN_STATIC = pix_t'(30);
	localparam pix_t MARGIN_MOTION = pix_t'(6);
	localparam pix_t UPPER_LIMIT = pix_t'(235);

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MOTION_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ARTIFACT_PROTECT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ODD_FRAME_MODE = 2'd2;

	localparam pix_t RESET_MOTION_THRESHOLD = pix_t'(12);

	typedef struct packed {
		pix_t cur_mid;
		pix_t other_mid;
		pix_t cur_above;
		pix_t cur_below;
		pix_t prev_above;
		pix_t prev_below;
		pix_t prev2_above;
		pix_t prev2_below;
		pix_t next_above;
		pix_t next_below;
		pix_t next2_above;
		pix_t next2_below;
	} mad_in_t;

	typedef struct packed {
		pix_t pixel_out;
		logic interpolated;
	} mad_out_t;

	typedef struct packed {
		pix_t motion_threshold;
		logic artifact_protect;
		logic odd_frame_mode;
	} mad_cfg_t;

	function automatic pix_t absdiff(input pix_t a, input pix_t b);
		pix_t r;
		r = (a > b) ? (a - b) : (b - a);
		return r;
	endfunction

endpackage

@@ rtl/mad_decide.sv @@
// ---------------------------------------------------------------------------
// mad_decide
// static test, spike check and weave or average selection for one pixel
// ---------------------------------------------------------------------------
module mad_decide (
	input  mad_pkg::mad_in_t  item,
	input  mad_pkg::mad_cfg_t cfg,
	output mad_pkg::mad_out_t result
);
	import mad_pkg::*;

	logic still;
	logic interp;
	logic spike_static;
	logic spike_motion;
	pix_t weave;
	logic [PIX_W:0] line_sum;

	function automatic logic is_spike(input pix_t w, input pix_t ab, input pix_t be,
		input pix_t margin);
		pix_t lo;
		logic [PIX_W:0] hi_raw;
		pix_t hi;
		lo = (w > margin) ? (w - margin) : '0;
		hi_raw = {1'b0, w} + {1'b0, margin};
		hi = (hi_raw > {1'b0, UPPER_LIMIT}) ? UPPER_LIMIT : hi_raw[PIX_W-1:0];
		return ((lo > ab) && (lo > be)) || ((hi < ab) && (hi < be));
	endfunction

	// nine differences all strictly below the threshold; zero threshold never passes
	always_comb begin
		still = (absdiff(item.cur_mid, item.other_mid) < cfg.motion_threshold)
			&& (absdiff(item.cur_above, item.prev_above) < cfg.motion_threshold)
			&& (absdiff(item.cur_below, item.prev_below) < cfg.motion_threshold)
			&& (absdiff(item.cur_above, item.prev2_above) < cfg.motion_threshold)
			&& (absdiff(item.cur_below, item.prev2_below) < cfg.motion_threshold)
			&& (absdiff(item.cur_above, item.next_above) < cfg.motion_threshold)
			&& (absdiff(item.cur_below, item.next_below) < cfg.motion_threshold)
			&& (absdiff(item.cur_above, item.next2_above) < cfg.motion_threshold)
			&& (absdiff(item.cur_below, item.next2_below) < cfg.motion_threshold);
	end

	assign weave = cfg.odd_frame_mode ? item.cur_mid : item.other_mid;
	assign spike_static = is_spike(weave, item.cur_above, item.cur_below, MARGIN_STATIC);
	assign spike_motion = is_spike(weave, item.cur_above, item.cur_below, MARGIN_MOTION);
	assign interp = still ? (cfg.artifact_protect && spike_static) : spike_motion;
	assign line_sum = {1'b0, item.cur_above} + {1'b0, item.cur_below};

	assign result.pixel_out = interp ? line_sum[PIX_W:1] : weave;
	assign result.interpolated = interp;

endmodule

@@ rtl/motion_adaptive_deint_pixel.sv @@
// ---------------------------------------------------------------------------
// motion_adaptive_deint_pixel
// per-pixel motion adaptive bob deinterlacer: weave or line average
// ---------------------------------------------------------------------------
// one item in, one item out, one item per clock sustained while out_ready is
// high. an accepted item lands in the input register, the decision logic (nine
// absolute differences, the spike check and the weave/average mux) sits
// between that register and the output register, and out_valid rises once the
// result is registered. in_ready stays high while the output register is
// empty or being drained; while a finished result waits on out_ready, the
// input register takes an item only if it is empty. configuration writes are
// always accepted (cfg_ready is tied high) and should only be issued while
// the pipeline is empty; writes to an index beyond the register list are
// dropped.
module motion_adaptive_deint_pixel (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mad_pkg::mad_in_t                   in_data,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output mad_pkg::mad_out_t                  out_data,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mad_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mad_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mad_pkg::*;

	// configuration registers
	pix_t motion_threshold_q;
	logic artifact_protect_q;
	logic odd_frame_mode_q;
	mad_cfg_t cfg;

	// pipeline registers
	logic valid_s1;
	mad_in_t item_s1;
	logic valid_s2;
	mad_out_t result_s2;
	mad_out_t result_comb;

	logic advance;
	logic in_fire;
	logic cfg_fire;

	// stage 2 moves when empty or drained this cycle
	assign advance = !valid_s2 || out_ready;
	// stage 1 can take a new item when empty or when its item moves on
	assign in_ready = !valid_s1 || advance;
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;

	// register writes, out of range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_threshold_q <= RESET_MOTION_THRESHOLD;
			artifact_protect_q <= 1'b0;
			odd_frame_mode_q <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_MOTION_THRESHOLD: motion_threshold_q <= cfg_data[PIX_W-1:0];
				REG_ARTIFACT_PROTECT: artifact_protect_q <= cfg_data[0];
				REG_ODD_FRAME_MODE: odd_frame_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.motion_threshold = motion_threshold_q;
	assign cfg.artifact_protect = artifact_protect_q;
	assign cfg.odd_frame_mode = odd_frame_mode_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// decision logic between the two registers
	mad_decide u_decide (
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_comb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = result_s2;

	// a held item in stage 1 is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage 1 item lost while stalled");

	// an accepted item always occupies stage 1 next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted item not captured");

	// stage 1 item moving on shows up as a result
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("result missing after stage 1 advanced");

	// an empty output register never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty output register");

	// odd frame mode write takes effect on the next cycle
	a_cfg_odd: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire && cfg_index == REG_ODD_FRAME_MODE |=> odd_frame_mode_q == $past(cfg_data[0]))
		else $error("odd frame mode write not applied");

endmodule
